>>> design/crpd_pkg.sv
// ----------------------------------------------------------------------------
// crpd_pkg: shared types and constants for the primary ray direction block
// Field widths, pipeline depths, register indexes and the payload structs.
// ----------------------------------------------------------------------------
package crpd_pkg;

	localparam int COORD_W       = 12;
	localparam int DIM_W         = 13;
	localparam int MAX_DIM       = 4096;
	localparam int TAN_W         = 16;
	localparam int COMP_W        = 16;
	localparam int BASIS_W       = 3 * COMP_W;
	localparam int DIR_FRAC_BITS = 15;
	localparam int DIR_W         = 16;

	// screen coordinate divider
	localparam int NUM_MAG_W  = 14;
	localparam int SCR_PROD_W = TAN_W + NUM_MAG_W;
	localparam int SCR_N_W    = SCR_PROD_W + 6;
	localparam int SCR_D_W    = DIM_W + 1;
	localparam int SCR_Q_W    = SCR_N_W - 1;
	localparam int SX_W       = SCR_Q_W + 1;
	localparam int SCR_LAT    = SCR_Q_W + 1;

	// direction sum and normalization
	localparam int PRD_W    = COMP_W + SX_W;
	localparam int D_W      = PRD_W + 2;
	localparam int MAG_W    = D_W - 1;
	localparam int POS_W    = 6;
	localparam int NRM_W    = 30;
	localparam int NRM_TOP  = NRM_W - 1;
	localparam int SQ_W     = 2 * NRM_W;
	localparam int SUM_W    = SQ_W + 2;
	localparam int RT_W     = SUM_W / 2;
	localparam int RT_REM_W = RT_W + 1;
	localparam int QUO_W    = DIR_FRAC_BITS + 1;
	localparam int DVN_W    = NRM_W + QUO_W + 1;
	localparam int DVD_W    = RT_W + 1;
	localparam int UNIT_LAT = 4 + (RT_W + 1) + (QUO_W + 1);

	// valid chain: input stage, screen divider, product, sum, unit, output
	localparam int DEPTH = 1 + SCR_LAT + 2 + UNIT_LAT + 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = BASIS_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASIS_U      = 3'd0,
		CFG_BASIS_V      = 3'd1,
		CFG_BASIS_W      = 3'd2,
		CFG_TAN_X        = 3'd3,
		CFG_TAN_Y        = 3'd4,
		CFG_IMAGE_WIDTH  = 3'd5,
		CFG_IMAGE_HEIGHT = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_row;
		logic [COORD_W-1:0] pixel_col;
	} pix_t;

	typedef struct packed {
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_y;
		logic signed [DIR_W-1:0] dir_z;
		logic [COORD_W-1:0]      out_row;
		logic [COORD_W-1:0]      out_col;
	} ray_t;

	typedef struct packed {
		logic [2:0] neg;
		logic       zero;
	} nrm_flags_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		if (d == '0)
			r = DIM_W'(1);
		else if (d > DIM_W'(MAX_DIM))
			r = DIM_W'(MAX_DIM);
		else
			r = d;
		return r;
	endfunction

endpackage

>>> design/crpd_screen.sv
// ----------------------------------------------------------------------------
// crpd_screen: screen coordinate pipeline
// tan * |num| * 16 / den, rounded half away from zero, one quotient bit a stage.
// ----------------------------------------------------------------------------
module crpd_screen import crpd_pkg::*; (
	input  logic                   clk,
	input  logic                   en,
	input  logic [NUM_MAG_W-1:0]   mag,
	input  logic                   neg,
	input  logic [TAN_W-1:0]       tan,
	input  logic [DIM_W-1:0]       den,
	output logic signed [SX_W-1:0] sx
);

	logic [SCR_PROD_W-1:0] prod;
	logic [SCR_N_W-1:0]    num;
	logic [SCR_D_W-1:0]    dv;

	logic [SCR_D_W-1:0] rem_s [0:SCR_Q_W];
	logic [SCR_Q_W-1:0] nq_s  [0:SCR_Q_W];
	logic               neg_s [0:SCR_Q_W];

	// (2p + den) / (2 den) with p = tan * mag * 16
	assign prod = SCR_PROD_W'(tan) * SCR_PROD_W'(mag);
	assign num  = SCR_N_W'({prod, 5'b0}) + SCR_N_W'(den);
	assign dv   = {den, 1'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= SCR_D_W'(num[SCR_N_W-1]);
			nq_s[0]  <= num[SCR_Q_W-1:0];
			neg_s[0] <= neg;
		end
	end

	for (genvar i = 0; i < SCR_Q_W; i++) begin : g_div
		logic [SCR_D_W:0] t;
		logic [SCR_D_W:0] dif;
		logic             ge;

		assign t   = {rem_s[i], nq_s[i][SCR_Q_W-1]};
		assign ge  = t >= {1'b0, dv};
		assign dif = t - {1'b0, dv};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? dif[SCR_D_W-1:0] : t[SCR_D_W-1:0];
				nq_s[i+1]  <= {nq_s[i][SCR_Q_W-2:0], ge};
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	assign sx = neg_s[SCR_Q_W] ? -$signed({1'b0, nq_s[SCR_Q_W]})
	                           : $signed({1'b0, nq_s[SCR_Q_W]});

endmodule

>>> design/crpd_norm.sv
// ----------------------------------------------------------------------------
// crpd_norm: direction normalization pipeline
// Aligns the three magnitudes, takes the root of the squared sum one bit a
// stage, then divides each component by twice the length one bit a stage.
// ----------------------------------------------------------------------------
module crpd_norm import crpd_pkg::*; (
	input  logic                        clk,
	input  logic                        en,
	input  logic [2:0][MAG_W-1:0]       mag,
	input  logic [2:0]                  neg,
	output logic [2:0][QUO_W-1:0]       quo,
	output nrm_flags_t                  flags
);

	// stage 1: largest magnitude
	logic [MAG_W-1:0]       mx01, mx;
	logic [2:0][MAG_W-1:0]  m_s1;
	logic [MAG_W-1:0]       mx_s1;
	logic [2:0]             neg_s1;

	assign mx01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
	assign mx   = (mx01 > mag[2]) ? mx01 : mag[2];

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1   <= mag;
			mx_s1  <= mx;
			neg_s1 <= neg;
		end
	end

	// stage 2: leading one of the largest
	logic [POS_W-1:0]      pos;
	logic [2:0][MAG_W-1:0] m_s2;
	logic [POS_W-1:0]      pos_s2;
	nrm_flags_t            fl_s2;

	always_comb begin
		pos = '0;
		for (int b = 0; b < MAG_W; b++)
			if (mx_s1[b])
				pos = POS_W'(b);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2       <= m_s1;
			pos_s2     <= pos;
			fl_s2.neg  <= neg_s1;
			fl_s2.zero <= (mx_s1 == '0);
		end
	end

	// stage 3: shift all three so the largest has its top bit at NRM_TOP
	logic [POS_W-1:0]      rsh, lsh;
	logic                  go_right;
	logic [2:0][NRM_W-1:0] sh;
	logic [2:0][NRM_W-1:0] sh_s3;
	nrm_flags_t            fl_s3;

	assign go_right = pos_s2 > POS_W'(NRM_TOP);
	assign rsh      = pos_s2 - POS_W'(NRM_TOP);
	assign lsh      = POS_W'(NRM_TOP) - pos_s2;

	for (genvar k = 0; k < 3; k++) begin : g_sh
		logic [MAG_W-1:0] shr, shl;
		assign shr   = m_s2[k] >> rsh;
		assign shl   = m_s2[k] << lsh;
		assign sh[k] = go_right ? shr[NRM_W-1:0] : shl[NRM_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sh_s3 <= sh;
			fl_s3 <= fl_s2;
		end
	end

	// stage 4: squares
	logic [2:0][SQ_W-1:0]  sq_s4;
	logic [2:0][NRM_W-1:0] sh_s4;
	nrm_flags_t            fl_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++)
				sq_s4[k] <= SQ_W'(sh_s3[k]) * SQ_W'(sh_s3[k]);
			sh_s4 <= sh_s3;
			fl_s4 <= fl_s3;
		end
	end

	// square root: sum enters at index 0, one root bit per stage
	logic [SUM_W-1:0]      sr_s   [0:RT_W];
	logic [RT_REM_W-1:0]   rrem_s [0:RT_W];
	logic [RT_W-1:0]       root_s [0:RT_W];
	logic [2:0][NRM_W-1:0] rm_s   [0:RT_W];
	nrm_flags_t            rfl_s  [0:RT_W];

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s[0]   <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
			rrem_s[0] <= '0;
			root_s[0] <= '0;
			rm_s[0]   <= sh_s4;
			rfl_s[0]  <= fl_s4;
		end
	end

	for (genvar j = 0; j < RT_W; j++) begin : g_rt
		logic [RT_REM_W+1:0] t, trial, dif;
		logic                ge;

		assign t     = {rrem_s[j], sr_s[j][SUM_W-1 -: 2]};
		assign trial = {1'b0, root_s[j], 2'b01};
		assign ge    = t >= trial;
		assign dif   = t - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rrem_s[j+1] <= ge ? dif[RT_REM_W-1:0] : t[RT_REM_W-1:0];
				root_s[j+1] <= {root_s[j][RT_W-2:0], ge};
				sr_s[j+1]   <= sr_s[j] << 2;
				rm_s[j+1]   <= rm_s[j];
				rfl_s[j+1]  <= rfl_s[j];
			end
		end
	end

	// divide: q = (m * 2^QUO_W + L) / (2L), quotient fits QUO_W bits
	logic [DVD_W-1:0]      drem_s [0:QUO_W][3];
	logic [QUO_W-1:0]      dnq_s  [0:QUO_W][3];
	logic [DVD_W-1:0]      dd_s   [0:QUO_W];
	nrm_flags_t            dfl_s  [0:QUO_W];

	for (genvar k = 0; k < 3; k++) begin : g_prep
		logic [DVN_W-1:0] n;
		assign n = DVN_W'({rm_s[RT_W][k], QUO_W'(0)}) + DVN_W'(root_s[RT_W]);

		always_ff @(posedge clk) begin
			if (en) begin
				drem_s[0][k] <= DVD_W'(n[DVN_W-1:QUO_W]);
				dnq_s[0][k]  <= n[QUO_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dd_s[0]  <= {root_s[RT_W], 1'b0};
			dfl_s[0] <= rfl_s[RT_W];
		end
	end

	for (genvar i = 0; i < QUO_W; i++) begin : g_dv
		for (genvar k = 0; k < 3; k++) begin : g_lane
			logic [DVD_W:0] t, dif;
			logic           ge;

			assign t   = {drem_s[i][k], dnq_s[i][k][QUO_W-1]};
			assign ge  = t >= {1'b0, dd_s[i]};
			assign dif = t - {1'b0, dd_s[i]};

			always_ff @(posedge clk) begin
				if (en) begin
					drem_s[i+1][k] <= ge ? dif[DVD_W-1:0] : t[DVD_W-1:0];
					dnq_s[i+1][k]  <= {dnq_s[i][k][QUO_W-2:0], ge};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dd_s[i+1]  <= dd_s[i];
				dfl_s[i+1] <= dfl_s[i];
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_out
		assign quo[k] = dnq_s[QUO_W][k];
	end
	assign flags = dfl_s[QUO_W];

endmodule

>>> design/camera_primary_ray_direction.sv
// ----------------------------------------------------------------------------
// camera_primary_ray_direction: pinhole camera primary ray generator
// Throughput: one pixel per cycle; the whole pipeline holds only while an
// output word is stalled. Depth is set by the two bit-serial dividers and the
// bit-serial square root. Reset clears all valid bits and loads the default
// camera (identity basis, unit tangents, 640 x 480).
// ----------------------------------------------------------------------------
module camera_primary_ray_direction import crpd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  pix_t                  pix,
	output logic                  ray_valid,
	input  logic                  ray_stall,
	output ray_t                  ray
);

	logic [BASIS_W-1:0] basis_u_q, basis_v_q, basis_w_q;
	logic [TAN_W-1:0]   tan_x_q, tan_y_q;
	logic [DIM_W-1:0]   width_q, height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			basis_u_q <= BASIS_W'(48'h0000_0000_4000);
			basis_v_q <= BASIS_W'(48'h0000_4000_0000);
			basis_w_q <= BASIS_W'(48'h4000_0000_0000);
			tan_x_q   <= TAN_W'(16'h1000);
			tan_y_q   <= TAN_W'(16'h1000);
			width_q   <= DIM_W'(640);
			height_q  <= DIM_W'(480);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_BASIS_U:      basis_u_q <= cfg_data;
				CFG_BASIS_V:      basis_v_q <= cfg_data;
				CFG_BASIS_W:      basis_w_q <= cfg_data;
				CFG_TAN_X:        tan_x_q   <= cfg_data[TAN_W-1:0];
				CFG_TAN_Y:        tan_y_q   <= cfg_data[TAN_W-1:0];
				CFG_IMAGE_WIDTH:  width_q   <= cfg_data[DIM_W-1:0];
				CFG_IMAGE_HEIGHT: height_q  <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// advance everything unless a finished word is held
	logic en;
	assign en        = !(ray_valid && ray_stall);
	assign pix_stall = !en;

	logic vld_s  [0:DEPTH-1];
	pix_t side_s [0:DEPTH-2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= pix_valid;
			for (int i = 1; i < DEPTH; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= pix;
			for (int i = 1; i < DEPTH - 1; i++)
				side_s[i] <= side_s[i-1];
		end
	end

	assign ray_valid = vld_s[DEPTH-1];

	// pixel center offsets from the image center, in half pixels
	logic [DIM_W-1:0]     wd, ht;
	logic signed [14:0]   num_x, num_y;
	logic [14:0]          abs_x, abs_y;
	logic signed [SX_W-1:0] sx, sy;

	assign wd    = clamp_dim(width_q);
	assign ht    = clamp_dim(height_q);
	assign num_x = $signed({2'b00, side_s[0].pixel_col, 1'b1}) - $signed({2'b00, wd});
	assign num_y = $signed({2'b00, ht}) - $signed({2'b00, side_s[0].pixel_row, 1'b1});
	assign abs_x = num_x[14] ? 15'(-num_x) : 15'(num_x);
	assign abs_y = num_y[14] ? 15'(-num_y) : 15'(num_y);

	crpd_screen u_scr_x (
		.clk (clk),
		.en  (en),
		.mag (abs_x[NUM_MAG_W-1:0]),
		.neg (num_x[14]),
		.tan (tan_x_q),
		.den (wd),
		.sx  (sx)
	);

	crpd_screen u_scr_y (
		.clk (clk),
		.en  (en),
		.mag (abs_y[NUM_MAG_W-1:0]),
		.neg (num_y[14]),
		.tan (tan_y_q),
		.den (ht),
		.sx  (sy)
	);

	// products of the basis components with the screen coordinates
	logic signed [PRD_W-1:0]  pu_s2 [3];
	logic signed [PRD_W-1:0]  pv_s2 [3];
	logic signed [COMP_W-1:0] cw_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pu_s2[k] <= PRD_W'($signed(basis_u_q[COMP_W*k +: COMP_W])) * PRD_W'(sx);
				pv_s2[k] <= PRD_W'($signed(basis_v_q[COMP_W*k +: COMP_W])) * PRD_W'(sy);
				cw_s2[k] <= $signed(basis_w_q[COMP_W*k +: COMP_W]);
			end
		end
	end

	// d = w*2^16 - u*sx - v*sy
	logic [2:0][MAG_W-1:0] mag_s3;
	logic [2:0]            neg_s3;

	for (genvar k = 0; k < 3; k++) begin : g_sum
		logic signed [D_W-1:0] d;
		logic [D_W-1:0]        ad;

		assign d  = D_W'($signed({cw_s2[k], 16'b0})) - D_W'(pu_s2[k]) - D_W'(pv_s2[k]);
		assign ad = d[D_W-1] ? D_W'(-d) : D_W'(d);

		always_ff @(posedge clk) begin
			if (en) begin
				mag_s3[k] <= ad[MAG_W-1:0];
				neg_s3[k] <= d[D_W-1];
			end
		end
	end

	logic [2:0][QUO_W-1:0] quo;
	nrm_flags_t            flags;

	crpd_norm u_norm (
		.clk   (clk),
		.en    (en),
		.mag   (mag_s3),
		.neg   (neg_s3),
		.quo   (quo),
		.flags (flags)
	);

	// saturate and sign the quotients
	logic [2:0][DIR_W-1:0] dir;

	for (genvar k = 0; k < 3; k++) begin : g_sat
		always_comb begin
			if (flags.zero)
				dir[k] = '0;
			else if (flags.neg[k])
				dir[k] = DIR_W'(-quo[k]);
			else if (quo[k] > QUO_W'(16'h7FFF))
				dir[k] = DIR_W'(16'h7FFF);
			else
				dir[k] = DIR_W'(quo[k]);
		end
	end

	ray_t ray_q;

	always_ff @(posedge clk) begin
		if (en) begin
			ray_q.dir_x   <= $signed(dir[0]);
			ray_q.dir_y   <= $signed(dir[1]);
			ray_q.dir_z   <= $signed(dir[2]);
			ray_q.out_row <= side_s[DEPTH-2].pixel_row;
			ray_q.out_col <= side_s[DEPTH-2].pixel_col;
		end
	end

	assign ray = ray_q;

endmodule
